[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, codes and default sizes for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Default geometry of the ring store.
  localparam int DefDepth     = 16;
  localparam int DefDataWidth = 32;

  // Width of the operation field.
  localparam int OpWidth     = 3;
  localparam int StatusWidth = 2;

  // Operation codes carried by each request.
  typedef enum logic [OpWidth-1:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // Status codes reported with every result.
  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_OUT  = 2'd2
  } state_t;

endpackage

[rtl/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = dq_pkg::DefDataWidth,
  parameter int DEPTH = dq_pkg::DefDepth,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue held in a ring of RAM slots.
// ----------------------------------------------------------------------------
// Usage
// A request is transferred on the rising edge at which start is high and busy
// is low. It carries an operation (none, push front, push back, pop front,
// pop back) and a data word that only pushes use. A push into a full queue
// or a pop from an empty one is refused with an error status and changes
// nothing.
// Every request produces exactly one result, shown for one cycle while
// out_valid is high: the front and back elements (zero when empty), the
// element count, the empty and full flags, and the status.
// The ring positions and count are updated and any push is written on the
// transfer edge; the next cycle reads the front and back slots from two
// mirrored RAMs, whose registered read data drives the result in the cycle
// after that. Busy is high only during the read cycle, so a new request may
// be transferred while a result is shown.
// The receiver cannot stall; each result is taken in the cycle it is shown.
// Reset (synchronous, rst_n low) empties the queue and drops any request in
// flight. The slot contents are not cleared; an empty slot is never read out.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DefDepth,
  parameter int DATA_WIDTH = dq_pkg::DefDataWidth,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [dq_pkg::OpWidth-1:0]      in_opcode,
  input  logic [DATA_WIDTH-1:0]           in_data_value,
  output logic                            out_valid,
  output logic [DATA_WIDTH-1:0]           out_front_value,
  output logic [DATA_WIDTH-1:0]           out_back_value,
  output logic [CW-1:0]                   out_item_count,
  output logic                            out_is_empty,
  output logic                            out_is_full,
  output logic [dq_pkg::StatusWidth-1:0]  out_status
);

  // Ring arithmetic that works for any depth, not only powers of two.
  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    ring_prev = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  dq_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [AW-1:0]   back_r, back_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  dq_pkg::status_t status_r, status_nxt;

  logic            accept;
  logic            is_full_now;
  logic            is_empty_now;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] back_data;

  assign accept       = start && !busy;
  assign is_full_now  = (count_r == CW'(DEPTH));
  assign is_empty_now = (count_r == '0);

  // Work out the effect of the request on the ring pointers and count.
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = dq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = back_r;
    case (in_opcode)
      dq_pkg::OP_PUSH_FRONT: begin
        if (is_full_now) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          front_nxt = ring_prev(front_r);
          wr_addr   = ring_prev(front_r);
          wr_en     = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (is_full_now) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          wr_addr   = back_r;
          wr_en     = accept;
          back_nxt  = ring_next(back_r);
          count_nxt = count_r + CW'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (is_empty_now) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          front_nxt = ring_next(front_r);
          count_nxt = count_r - CW'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (is_empty_now) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          back_nxt  = ring_prev(back_r);
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        // No operation, and unused codes behave the same way.
        status_nxt = dq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // The status only travels with the result, so it needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // Controller: accept, read the two ends, present the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dq_pkg::S_IDLE: begin
        if (accept) state_nxt = dq_pkg::S_READ;
      end
      dq_pkg::S_READ: begin
        state_nxt = dq_pkg::S_OUT;
      end
      dq_pkg::S_OUT: begin
        state_nxt = accept ? dq_pkg::S_READ : dq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    rd_en     = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      dq_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      dq_pkg::S_READ: begin
        busy  = 1'b1;
        rd_en = 1'b1;
      end
      dq_pkg::S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Two mirrored copies of the ring, so that both ends can be read at once.
  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_front_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_value),
    .rd_en   (rd_en),
    .rd_addr (front_r),
    .rd_data (front_data)
  );

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_back_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_value),
    .rd_en   (rd_en),
    .rd_addr (ring_prev(back_r)),
    .rd_data (back_data)
  );

  // The count and status registers hold until the next transfer edge, which
  // is no earlier than the end of the result cycle.
  assign out_front_value = is_empty_now ? '0 : front_data;
  assign out_back_value  = is_empty_now ? '0 : back_data;
  assign out_item_count  = count_r;
  assign out_is_empty    = is_empty_now;
  assign out_is_full     = is_full_now;
  assign out_status      = status_r;

endmodule

[rtl/dq_checker.sv]
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker #(
  parameter int DEPTH      = dq_pkg::DefDepth,
  parameter int DATA_WIDTH = dq_pkg::DefDataWidth,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [DATA_WIDTH-1:0]          out_front_value,
  input logic [DATA_WIDTH-1:0]          out_back_value,
  input logic [CW-1:0]                  out_item_count,
  input logic                           out_is_empty,
  input logic                           out_is_full,
  input logic [dq_pkg::StatusWidth-1:0] out_status
);

  // Every transfer yields its result once the read of the two ends has completed.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result missing two cycles after a transfer");

  // The empty flag agrees with the count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_item_count == '0)))
    else $error("empty flag disagrees with item count");

  // An empty queue shows zero at both ends.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_front_value == '0) && (out_back_value == '0))
    else $error("empty queue shows a non-zero element");

  // A refused push is only reported when the queue is full.
  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dq_pkg::ST_FULL) |-> out_is_full)
    else $error("push refused while not full");

  // A refused pop is only reported when the queue is empty.
  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dq_pkg::ST_EMPTY) |-> out_is_empty)
    else $error("pop refused while not empty");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value),
  .out_item_count  (out_item_count),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full),
  .out_status      (out_status)
);
